// ===== design/psn_pkg.sv =====
// ----------------------------------------------------------------------------
// psn_pkg: shared definitions for the azimuth sector finder
// Constants, the arctangent table and the CORDIC step functions.
// ----------------------------------------------------------------------------
package psn_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int SECTORS         = 64;
  localparam int MARGIN_DIVISOR  = 8;
  localparam int COORD_BITS      = 16;

  localparam int CORDIC_STEPS    = 31;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Port widths of the word fields.
  localparam int IN_COORD_W      = 16;
  localparam int SECTOR_FIELD_W  = 6;
  localparam int COUNT_W         = 2;

  // Three guard bits cover the CORDIC gain and the first step's growth.
  localparam int XY_W            = COORD_BITS + 3;
  localparam int ACC_W           = 32;
  localparam int SECT_W          = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int PROD_W          = ANGLE_BITS + SECT_W;
  localparam int MARG_W          = ANGLE_BITS + $clog2(MARGIN_DIVISOR);

  localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(longint'(1) << (ACC_W - 1));
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(longint'(1) << (ACC_W - 1 - ANGLE_BITS));

  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_TWO = COUNT_W'(2);

  // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
  localparam logic [ACC_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
    logic                   zero;
  } cordic_t;

  // One vectoring rotation; shifts are arithmetic.
  function automatic cordic_t cordic_step(cordic_t s, int i);
    cordic_t r;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    xs = s.x >>> i;
    ys = s.y >>> i;
    r  = s;
    if (!s.y[XY_W-1]) begin
      r.x   = s.x + ys;
      r.y   = s.y - xs;
      r.acc = s.acc + ATAN_TURN[i];
    end else begin
      r.x   = s.x - ys;
      r.y   = s.y + xs;
      r.acc = s.acc - ATAN_TURN[i];
    end
    return r;
  endfunction

  // The rotations that one pipeline stage performs.
  function automatic cordic_t cordic_stage(cordic_t s, int stage);
    cordic_t r;
    r = s;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      if (stage * STEPS_PER_STAGE + j < CORDIC_STEPS) begin
        r = cordic_step(r, stage * STEPS_PER_STAGE + j);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/phi_sector_with_neighbor.sv =====
// ----------------------------------------------------------------------------
// phi_sector_with_neighbor: azimuth sector finder with boundary neighbor
// Pipelined vectoring CORDIC gives the hit azimuth, which is then binned
// into sectors; hits near a sector edge also report the adjacent sector.
// ----------------------------------------------------------------------------
// Registers in order: entry stage, rotation stages, position, output word.
// Throughput: one word per cycle; the whole pipeline holds while a result
// waits under out_stall, and in_stall follows that condition.
// Reset (synchronous, rst_n low) empties the pipeline and clears the
// half-sector offset register to 0. The config port is always ready.
// ----------------------------------------------------------------------------
module phi_sector_with_neighbor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [psn_pkg::IN_COORD_W-1:0]  in_x_coord,
  input  logic signed [psn_pkg::IN_COORD_W-1:0]  in_y_coord,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [psn_pkg::SECTOR_FIELD_W-1:0]     out_first_sector,
  output logic [psn_pkg::SECTOR_FIELD_W-1:0]     out_second_sector,
  output logic [psn_pkg::COUNT_W-1:0]            out_sector_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_half_sector_offset
);

  localparam int CS = psn_pkg::CORDIC_STAGES;
  localparam int AB = psn_pkg::ANGLE_BITS;
  localparam int PW = psn_pkg::PROD_W;
  localparam int SW = psn_pkg::SECT_W;
  localparam int MW = psn_pkg::MARG_W;

  localparam longint TURN_L = longint'(1) << AB;
  localparam logic [PW-1:0] HALF_SECT = PW'(TURN_L / 2);
  localparam logic [PW-1:0] WRAP_ADD  = PW'(TURN_L * psn_pkg::SECTORS - TURN_L / 2);
  localparam logic [MW-1:0] LOW_LIM   = MW'(TURN_L);
  localparam logic [MW-1:0] UP_LIM    = MW'(TURN_L * (psn_pkg::MARGIN_DIVISOR - 1));
  localparam logic [SW-1:0] LAST_SECT = SW'(psn_pkg::SECTORS - 1);

  logic                     adv;
  logic                     half_offset_r;

  psn_pkg::cordic_t         stg_r   [0:CS];
  psn_pkg::cordic_t         stg_nxt [0:CS];
  logic [CS:0]              vld_r;

  logic [PW-1:0]            pos_r;
  logic [PW-1:0]            pos_nxt;
  logic                     pos_vld_r;

  logic [SW-1:0]            first_nxt;
  logic [SW-1:0]            second_nxt;
  logic [psn_pkg::COUNT_W-1:0] count_nxt;

  logic                     out_valid_r;
  logic [psn_pkg::SECTOR_FIELD_W-1:0] out_first_r;
  logic [psn_pkg::SECTOR_FIELD_W-1:0] out_second_r;
  logic [psn_pkg::COUNT_W-1:0]        out_count_r;

  // The pipeline moves as one whenever the output register can take a word.
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_offset_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      half_offset_r <= cfg_half_sector_offset;
    end
  end

  // Entry stage: sign extension and the half-turn pre-rotation for x < 0; then the rotations.
  always_comb begin
    logic signed [psn_pkg::XY_W-1:0] sx;
    logic signed [psn_pkg::XY_W-1:0] sy;
    sx = psn_pkg::XY_W'(signed'(in_x_coord[psn_pkg::COORD_BITS-1:0]));
    sy = psn_pkg::XY_W'(signed'(in_y_coord[psn_pkg::COORD_BITS-1:0]));
    stg_nxt[0].zero = (sx == '0) && (sy == '0);
    if (sx[psn_pkg::XY_W-1]) begin
      stg_nxt[0].x   = -sx;
      stg_nxt[0].y   = -sy;
      stg_nxt[0].acc = psn_pkg::HALF_TURN;
    end else begin
      stg_nxt[0].x   = sx;
      stg_nxt[0].y   = sy;
      stg_nxt[0].acc = '0;
    end
    for (int k = 1; k <= CS; k++) begin
      stg_nxt[k] = psn_pkg::cordic_stage(stg_r[k-1], k - 1);
    end
  end

  // Round the angle to AB bits and scale it to sector units.
  always_comb begin
    logic [psn_pkg::ACC_W-1:0] acc_rnd;
    logic [AB-1:0]             angle;
    acc_rnd = stg_r[CS].acc + psn_pkg::ROUND_ADD;
    angle   = stg_r[CS].zero ? '0 : acc_rnd[psn_pkg::ACC_W-1 -: AB];
    pos_nxt = PW'(angle) * PW'(psn_pkg::SECTORS);
  end

  // The position within a sector, times the margin divisor, is compared
  // with one sector width from either edge.
  always_comb begin
    logic [PW-1:0] pos;
    logic [AB-1:0] frac;
    logic [MW-1:0] scaled;
    logic [SW-1:0] prev_sect;
    logic [SW-1:0] next_sect;
    if (half_offset_r) begin
      pos = (pos_r >= HALF_SECT) ? pos_r - HALF_SECT : pos_r + WRAP_ADD;
    end else begin
      pos = pos_r;
    end
    first_nxt = pos[PW-1 -: SW];
    frac      = pos[AB-1:0];
    scaled    = MW'(frac) * MW'(psn_pkg::MARGIN_DIVISOR);
    prev_sect = (first_nxt == '0) ? LAST_SECT : first_nxt - SW'(1);
    next_sect = (first_nxt == LAST_SECT) ? '0 : first_nxt + SW'(1);
    if (scaled < LOW_LIM) begin
      second_nxt = prev_sect;
      count_nxt  = psn_pkg::COUNT_TWO;
    end else if (scaled >= UP_LIM) begin
      second_nxt = next_sect;
      count_nxt  = psn_pkg::COUNT_TWO;
    end else begin
      second_nxt = '0;
      count_nxt  = psn_pkg::COUNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pos_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[CS-1:0], in_valid};
      pos_vld_r   <= vld_r[CS];
      out_valid_r <= pos_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= CS; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
      pos_r        <= pos_nxt;
      out_first_r  <= psn_pkg::SECTOR_FIELD_W'(first_nxt);
      out_second_r <= psn_pkg::SECTOR_FIELD_W'(second_nxt);
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_sector  = out_first_r;
  assign out_second_sector = out_second_r;
  assign out_sector_count  = out_count_r;

endmodule

// ===== design/psn_checker.sv =====
// ----------------------------------------------------------------------------
// psn_checker: port-level checks for the sector finder
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module psn_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [psn_pkg::SECTOR_FIELD_W-1:0]     out_first_sector,
  input logic [psn_pkg::SECTOR_FIELD_W-1:0]     out_second_sector,
  input logic [psn_pkg::COUNT_W-1:0]            out_sector_count
);

  localparam logic [psn_pkg::SECTOR_FIELD_W-1:0] LAST_SECT =
    psn_pkg::SECTOR_FIELD_W'(psn_pkg::SECTORS - 1);
  localparam logic [psn_pkg::SECTOR_FIELD_W-1:0] ONE_SECT =
    psn_pkg::SECTOR_FIELD_W'(1);

  // No word comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word stays and holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_sector) &&
      $stable(out_second_sector) && $stable(out_sector_count))
    else $error("stalled result word changed");

  // A single-sector result carries no neighbor.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sector_count != psn_pkg::COUNT_TWO) |->
      (out_sector_count == psn_pkg::COUNT_ONE) && (out_second_sector == '0))
    else $error("bad count or stray neighbor sector");

  // A reported neighbor is adjacent, wrapping around the circle.
  a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sector_count == psn_pkg::COUNT_TWO) |->
      (out_second_sector == out_first_sector + ONE_SECT) ||
      (out_first_sector == out_second_sector + ONE_SECT) ||
      ((out_first_sector == '0) && (out_second_sector == LAST_SECT)) ||
      ((out_second_sector == '0) && (out_first_sector == LAST_SECT)))
    else $error("neighbor sector is not adjacent");

endmodule

bind phi_sector_with_neighbor psn_checker u_psn_checker (.*);
